@@ design/u16u8_pkg.sv @@
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
package u16u8_pkg;

   // Result kind carried on the result channel's tuser
   typedef enum logic [1:0] {
      ST_DATA     = 2'd0,
      ST_NAME_END = 2'd1,
      ST_UNPAIRED = 2'd2,
      ST_LONE_LOW = 2'd3
   } status_type;

   localparam int UNIT_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int CP_W      = 21;
   localparam int MAX_BYTES = 4;
   localparam int IDX_W     = $clog2(MAX_BYTES);

   // Command queue between the classifier and the byte emitter
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [UNIT_W-1:0] HIGH_FIRST = 16'hD800;
   localparam logic [UNIT_W-1:0] HIGH_LAST  = 16'hDBFF;
   localparam logic [UNIT_W-1:0] LOW_FIRST  = 16'hDC00;
   localparam logic [UNIT_W-1:0] LOW_LAST   = 16'hDFFF;
   localparam logic [UNIT_W-1:0] ONE_BYTE_MAX = 16'h007F;
   localparam logic [UNIT_W-1:0] TWO_BYTE_MAX = 16'h07FF;
   localparam logic [CP_W-1:0]   SUPP_BASE    = 21'h10000;

   // One classified item: up to four bytes, index of the final one, kind
   typedef struct packed {
      logic [MAX_BYTES-1:0][BYTE_W-1:0] utf_bytes;
      logic [IDX_W-1:0]                 last_idx;
      status_type                       status;
   } cmd_type;

endpackage

@@ design/u16u8_front.sv @@
// Front end: accepts code units, tracks surrogate pairing, builds byte commands.
module u16u8_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [u16u8_pkg::UNIT_W-1:0]    req_tdata,
   input  logic                            queue_full,
   output logic                            push,
   output u16u8_pkg::cmd_type              push_cmd
);

   logic                               pending_ff, pending_in;
   logic [9:0]                         held_ff, held_in;
   logic                               accept;
   logic                               is_high, is_low, produces;
   logic [u16u8_pkg::UNIT_W-1:0]       u;
   logic [u16u8_pkg::CP_W-1:0]         cp;
   u16u8_pkg::cmd_type                 cmd;

   assign u          = req_tdata;
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign is_high    = u inside {[u16u8_pkg::HIGH_FIRST:u16u8_pkg::HIGH_LAST]};
   assign is_low     = u inside {[u16u8_pkg::LOW_FIRST:u16u8_pkg::LOW_LAST]};
   assign cp         = u16u8_pkg::SUPP_BASE + {1'b0, held_ff, u[9:0]};

   always_comb begin
      cmd        = '0;
      cmd.status = u16u8_pkg::ST_DATA;
      produces   = 1'b1;
      pending_in = pending_ff;
      held_in    = held_ff;
      if (pending_ff) begin
         pending_in = 1'b0;
         held_in    = '0;
         if (is_low) begin
            cmd.utf_bytes[0] = {5'b11110, cp[20:18]};
            cmd.utf_bytes[1] = {2'b10, cp[17:12]};
            cmd.utf_bytes[2] = {2'b10, cp[11:6]};
            cmd.utf_bytes[3] = {2'b10, cp[5:0]};
            cmd.last_idx     = 2'd3;
         end else begin
            // drop the unit that broke the pair
            cmd.status = u16u8_pkg::ST_UNPAIRED;
         end
      end else if (u == '0) begin
         cmd.status = u16u8_pkg::ST_NAME_END;
      end else if (is_high) begin
         produces   = 1'b0;
         pending_in = 1'b1;
         held_in    = u[9:0];
      end else if (is_low) begin
         cmd.status = u16u8_pkg::ST_LONE_LOW;
      end else if (u <= u16u8_pkg::ONE_BYTE_MAX) begin
         cmd.utf_bytes[0] = u[7:0];
         cmd.last_idx     = 2'd0;
      end else if (u <= u16u8_pkg::TWO_BYTE_MAX) begin
         cmd.utf_bytes[0] = {3'b110, u[10:6]};
         cmd.utf_bytes[1] = {2'b10, u[5:0]};
         cmd.last_idx     = 2'd1;
      end else begin
         cmd.utf_bytes[0] = {4'b1110, u[15:12]};
         cmd.utf_bytes[1] = {2'b10, u[11:6]};
         cmd.utf_bytes[2] = {2'b10, u[5:0]};
         cmd.last_idx     = 2'd2;
      end
   end

   assign push     = accept && produces;
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         held_ff    <= '0;
      end else if (accept) begin
         pending_ff <= pending_in;
         held_ff    <= held_in;
      end
   end

endmodule

@@ design/u16u8_cmd_queue.sv @@
// Short command queue between the front end and the byte emitter.
module u16u8_cmd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  u16u8_pkg::cmd_type    push_cmd,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty,
   output u16u8_pkg::cmd_type    head
);

   u16u8_pkg::cmd_type                 entries_ff [u16u8_pkg::QUEUE_DEPTH];
   logic [u16u8_pkg::QUEUE_AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [u16u8_pkg::QUEUE_AW:0]       count_ff, count_in;

   assign full      = count_ff == (u16u8_pkg::QUEUE_AW+1)'(u16u8_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

@@ design/u16u8_back.sv @@
// Back end: walks each command one byte per cycle, as rsp_tready allows, into the output register.
module u16u8_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  u16u8_pkg::cmd_type            cmd,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [u16u8_pkg::BYTE_W-1:0]  rsp_tdata,
   output logic [1:0]                    rsp_tuser,
   output logic                          rsp_tlast
);

   logic [u16u8_pkg::IDX_W-1:0]  idx_ff;
   logic                         valid_ff;
   logic [u16u8_pkg::BYTE_W-1:0] byte_ff;
   u16u8_pkg::status_type        status_ff;
   logic                         last_ff;
   logic                         load, at_last;

   assign load    = cmd_valid && (!valid_ff || rsp_tready);
   assign at_last = idx_ff == cmd.last_idx;
   assign pop     = load && at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= at_last ? '0 : idx_ff + 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= cmd.utf_bytes[idx_ff];
         status_ff <= cmd.status;
         last_ff   <= at_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

endmodule

@@ design/utf16_to_utf8_transcoder_unit.sv @@
// Top level of the UTF-16 to UTF-8 transcoder.
//
//   channel  | direction | tdata                 | tuser        | tlast
//   ---------+-----------+-----------------------+--------------+-------------
//   req_     | in        | [15:0] code_unit      | -            | -
//   rsp_     | out       | [7:0] out_byte        | [1:0] status | last_of_run
//
// Each result transaction carries one byte: a code unit yields 1 to 3
// results for a BMP unit, 4 for a completed surrogate pair, 1 for a status;
// a held high surrogate yields none. The byte emitter's output register
// gives one byte per cycle while rsp_tready stays high and commands wait.
// Reset is synchronous and clears the held surrogate, the queue and the
// output valid. A full two-entry command queue stalls req_tready; a
// stalled result holds in the output register while the front keeps going.
module utf16_to_utf8_transcoder_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // [15:0] code_unit
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // [7:0] out_byte
   output logic [1:0]   rsp_tuser,   // [1:0] status
   output logic         rsp_tlast
);

   // Front-to-queue and queue-to-back command traffic
   logic                 push, pop, queue_full, queue_valid;
   u16u8_pkg::cmd_type   push_cmd, head_cmd;

   // Classify the unit and hold surrogate state
   u16u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Decouple classification from byte emission
   u16u8_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_valid),
      .head      (head_cmd)
   );

   // Emit one byte per transaction, advancing through each command
   u16u8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_valid),
      .cmd        (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ design/u16u8_checker.sv @@
// Port-level checks of the transcoder and their binding to the top level.
module u16u8_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // Output register comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // Stalled transaction holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Status results stand alone with a zero byte
   a_status_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != u16u8_pkg::ST_DATA |-> rsp_tlast && rsp_tdata == 8'h00)
      else $error("status result not single or byte nonzero");

   // A single-byte code ends its run
   a_ascii_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == u16u8_pkg::ST_DATA && !rsp_tdata[7] |-> rsp_tlast)
      else $error("ASCII byte not last of run");

   // A multi-byte lead byte never ends its run
   a_lead_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == u16u8_pkg::ST_DATA && rsp_tdata[7:6] == 2'b11
         |-> !rsp_tlast)
      else $error("lead byte marked last");

endmodule

bind utf16_to_utf8_transcoder_unit u16u8_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

@@ verif/utf16_to_utf8_transcoder_unit_tb.sv @@
// Self-checking testbench of the UTF-16 to UTF-8 transcoder with random stream pacing.
module utf16_to_utf8_transcoder_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_UNITS   = 146;
   localparam int LONG_HOLD_AT   = 40;   // result count at which the receiver holds off
   localparam int LONG_HOLD_LEN  = 150;  // cycles of that hold-off
   localparam int DRAIN_CYCLES   = 20;

   // Corner code units: byte-count boundaries, both surrogate ranges at their
   // ends, name ends, and three ways a held high surrogate can go unpaired.
   localparam logic [15:0] DIRECTED_UNITS [24] = '{
      16'h0041, 16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800,
      16'hFFFF, 16'hD7FF, 16'hE000,
      16'hD800, 16'hDC00,   // lowest supplementary point
      16'hDBFF, 16'hDFFF,   // highest supplementary point
      16'hDC00, 16'hDFFF,   // lone low surrogates
      16'hD801, 16'h0000,   // unpaired high, terminator swallowed
      16'hDA00, 16'hDB00,   // unpaired high, second high swallowed
      16'hD900, 16'h0041,   // unpaired high, ASCII swallowed
      16'hD834, 16'hDD1E,   // ordinary pair
      16'h0000
   };

   // One expected result transaction
   typedef struct packed {
      logic [7:0]            out_byte;
      u16u8_pkg::status_type status;
      logic                  last_of_run;
   } utf8_result_type;

   // Predicts the byte stream from accepted code units and checks results in order
   class utf8_scoreboard;
      utf8_result_type bytes_due[$];
      logic [9:0]   held_bits;
      logic         high_held;
      int           failures;
      int           units_seen, results_seen;
      int           name_ends, pairs, unpaired, lone_lows;

      function new();
         held_bits  = '0;
         high_held  = 1'b0;
         failures   = 0;
         units_seen = 0;
         results_seen = 0;
         name_ends  = 0;
         pairs      = 0;
         unpaired   = 0;
         lone_lows  = 0;
      endfunction

      function void push_result(logic [7:0] b, u16u8_pkg::status_type st, logic last);
         utf8_result_type r;
         r.out_byte    = b;
         r.status      = st;
         r.last_of_run = last;
         bytes_due.insert(bytes_due.size(), r);
      endfunction

      function void encode_point(int unsigned cp);
         if (cp <= 32'h7F) begin
            push_result(cp[7:0], u16u8_pkg::ST_DATA, 1'b1);
         end else if (cp <= 32'h7FF) begin
            push_result(8'hC0 | cp[10:6], u16u8_pkg::ST_DATA, 1'b0);
            push_result(8'h80 | cp[5:0], u16u8_pkg::ST_DATA, 1'b1);
         end else if (cp <= 32'hFFFF) begin
            push_result(8'hE0 | cp[15:12], u16u8_pkg::ST_DATA, 1'b0);
            push_result(8'h80 | cp[11:6], u16u8_pkg::ST_DATA, 1'b0);
            push_result(8'h80 | cp[5:0], u16u8_pkg::ST_DATA, 1'b1);
         end else begin
            push_result(8'hF0 | cp[20:18], u16u8_pkg::ST_DATA, 1'b0);
            push_result(8'h80 | cp[17:12], u16u8_pkg::ST_DATA, 1'b0);
            push_result(8'h80 | cp[11:6], u16u8_pkg::ST_DATA, 1'b0);
            push_result(8'h80 | cp[5:0], u16u8_pkg::ST_DATA, 1'b1);
         end
      endfunction

      // Note one accepted code unit and queue the bytes it must produce
      function void note_unit(logic [15:0] u);
         logic is_high, is_low;
         int unsigned cp;
         is_high = (u >= u16u8_pkg::HIGH_FIRST) && (u <= u16u8_pkg::HIGH_LAST);
         is_low  = (u >= u16u8_pkg::LOW_FIRST) && (u <= u16u8_pkg::LOW_LAST);
         units_seen++;
         if (high_held) begin
            if (is_low) begin
               cp = 32'h10000 + {held_bits, u[9:0]};
               encode_point(cp);
               pairs++;
            end else begin
               push_result(8'h00, u16u8_pkg::ST_UNPAIRED, 1'b1);
               unpaired++;
            end
            high_held = 1'b0;
            held_bits = '0;
         end else if (u == 16'h0000) begin
            push_result(8'h00, u16u8_pkg::ST_NAME_END, 1'b1);
            name_ends++;
         end else if (is_high) begin
            held_bits = u[9:0];
            high_held = 1'b1;
         end else if (is_low) begin
            push_result(8'h00, u16u8_pkg::ST_LONE_LOW, 1'b1);
            lone_lows++;
         end else begin
            encode_point(32'(u));
         end
      endfunction

      // Compare one accepted result against the oldest expectation
      function void check_result(logic [7:0] b, logic [1:0] st, logic last);
         utf8_result_type want;
         results_seen++;
         if (bytes_due.size() == 0) begin
            $error("unexpected result: out_byte %02h status %0d last_of_run %0b", b, st, last);
            failures++;
            return;
         end
         want = bytes_due.pop_front();
         if (b !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte, b);
            failures++;
         end
         if (st !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, st);
            failures++;
         end
         if (last !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b", want.last_of_run, last);
            failures++;
         end
      endfunction

      function int pending();
         return bytes_due.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [15:0] code_unit
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] out_byte
   logic [1:0]  rsp_tuser;        // [1:0] status
   logic        rsp_tlast;        // last_of_run

   utf8_scoreboard sb = new();

   int req_quiet = 0;   // remaining zero-gap transactions on the request side
   int rsp_quiet = 0;   // remaining zero-stall transactions on the result side
   int random_sent = 0;

   utf16_to_utf8_transcoder_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Draw a random wait; now and then start a run of back-to-back transactions
   function automatic int draw_idle(ref int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 5) == 0) begin
         quiet_left = $urandom_range(6, 20);
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   // Offer one code unit and hold it until the block takes it. Drop tvalid only
   // when a gap follows, so a back-to-back transaction never toggles it.
   task automatic offer_unit(logic [15:0] u);
      int gap;
      gap = draw_idle(req_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= u;
      do @(posedge clock); while (!req_tready);
      sb.note_unit(u);
   endtask

   task automatic offer_random_unit();
      offer_unit(16'($urandom_range(0, 16'hFFFF)));
      random_sent++;
   endtask

   // Well-formed name: 1 to 8 characters of random encoded length, then the terminator
   task automatic offer_name();
      int chars;
      chars = $urandom_range(1, 8);
      repeat (chars) begin
         case ($urandom_range(0, 3))
            0: offer_unit(16'($urandom_range(1, 16'h007F)));
            1: offer_unit(16'($urandom_range(16'h0080, 16'h07FF)));
            2: begin
               if ($urandom_range(0, 1) == 1)
                  offer_unit(16'($urandom_range(16'h0800, 16'hD7FF)));
               else
                  offer_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
            end
            default: begin
               offer_unit(u16u8_pkg::HIGH_FIRST + 16'($urandom_range(0, 1023)));
               offer_unit(u16u8_pkg::LOW_FIRST + 16'($urandom_range(0, 1023)));
               random_sent++;
            end
         endcase
         random_sent++;
      end
      offer_unit(16'h0000);
      random_sent++;
   endtask

   // Result side: stall at random, once for a long stretch so the queue fills
   // and req_tready drops while the sender keeps offering.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (sb.results_seen == LONG_HOLD_AT)
            stall = LONG_HOLD_LEN;
         else
            stall = draw_idle(rsp_quiet);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Stimulus and end of run
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_UNITS[i])
         offer_unit(DIRECTED_UNITS[i]);

      // Mostly well-formed names, with noise and broken surrogate sequences mixed in
      while (random_sent < RANDOM_UNITS) begin
         case ($urandom_range(0, 9))
            7: offer_random_unit();
            8: begin
               offer_unit(u16u8_pkg::LOW_FIRST + 16'($urandom_range(0, 1023)));
               random_sent++;
            end
            9: begin
               offer_unit(u16u8_pkg::HIGH_FIRST + 16'($urandom_range(0, 1023)));
               random_sent++;
               offer_random_unit();
            end
            default: offer_name();
         endcase
      end
      req_tvalid <= 1'b0;

      // Drain expectations, then give stray results time to show up
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d code units, checked %0d result bytes and statuses.",
               sb.units_seen, sb.results_seen);
      $display("Saw %0d name ends, %0d surrogate pairs, %0d unpaired highs, %0d lone lows.",
               sb.name_ends, sb.pairs, sb.unpaired, sb.lone_lows);
      if (sb.failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #200us;
      $display("FAIL");
      $finish;
   end

endmodule
